// ----- src/gls_pkg.sv -----
package gls_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_SLOTS    = 4;
  localparam int SLOT_W       = $clog2(ROW_SLOTS);

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SHARPEN_GAIN = 2'd2;

  typedef logic [31:0]           pix_t;
  typedef logic [4:0][31:0]      col_t;
  typedef logic [4:0][4:0][31:0] win_t;

  // one emitted window reduced to deviation and centre per channel
  typedef struct packed {
    logic [3:0][13:0] dev;
    logic [3:0][7:0]  centre;
    logic             last;
    logic             fend;
  } kern_t;

  // corners + 2*ring - 4*cross - 12*centre for one 8-bit channel
  function automatic logic [13:0] kernel_dev(win_t w, logic [1:0] ch);
    logic [4:0]  sh;
    logic [10:0] corners;
    logic [11:0] ring;
    logic [9:0]  near;
    logic [7:0]  ctr;
    logic [13:0] pos;
    logic [13:0] neg;
    logic [15:0] d;
    sh      = {ch, 3'b000};
    corners = 11'(w[0][0][sh +: 8]) + 11'(w[0][4][sh +: 8]) +
              11'(w[4][0][sh +: 8]) + 11'(w[4][4][sh +: 8]);
    ring    = '0;
    for (int k = 1; k <= 3; k++) begin
      ring = ring + 12'(w[0][k][sh +: 8]) + 12'(w[4][k][sh +: 8]) +
             12'(w[k][0][sh +: 8]) + 12'(w[k][4][sh +: 8]);
    end
    near    = 10'(w[1][2][sh +: 8]) + 10'(w[3][2][sh +: 8]) +
              10'(w[2][1][sh +: 8]) + 10'(w[2][3][sh +: 8]);
    ctr     = w[2][2][sh +: 8];
    pos     = 14'(corners) + {1'b0, ring, 1'b0};
    neg     = {2'b00, near, 2'b00} + 14'(ctr) * 14'd12;
    d       = 16'(pos) - 16'(neg);
    return d[13:0];
  endfunction

endpackage

// ----- src/gls_in_if.sv -----
interface gls_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, command, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, command, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

// ----- src/gls_out_if.sv -----
interface gls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       last_in_run;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, last_in_run,
                  frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, last_in_run,
                frame_end, output ready);
endinterface

// ----- src/gls_scale.sv -----
module gls_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [17:0]   gain_i,
  input  logic          k_valid_i,
  output logic          k_ready_o,
  input  gls_pkg::kern_t k_i,
  gls_out_if.source     out_o
);

  logic                   p_v_q;
  logic signed [31:0]     prod_q [4];
  logic [3:0][7:0]        cen_q;
  logic                   last_q;
  logic                   fend_q;
  logic                   o_v_q;
  logic [3:0][7:0]        res_q;
  logic                   o_last_q;
  logic                   o_fend_q;
  logic [3:0][7:0]        res_d;
  logic                   o_free;

  assign o_free    = !o_v_q || out_o.ready;
  assign k_ready_o = !p_v_q || o_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (k_ready_o) p_v_q <= k_valid_i;
      if (o_free) o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_ready_o && k_valid_i) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= 32'($signed(gain_i) * $signed(k_i.dev[c]));
      end
      cen_q  <= k_i.centre;
      last_q <= k_i.last;
      fend_q <= k_i.fend;
    end
    if (o_free && p_v_q) begin
      res_q    <= res_d;
      o_last_q <= last_q;
      o_fend_q <= fend_q;
    end
  end

  // centre*65536 - gain*dev, rounded half up, clamped to a byte
  always_comb begin
    logic signed [33:0] t;
    for (int c = 0; c < 4; c++) begin
      t = $signed({10'd0, cen_q[c], 16'h0000}) - $signed({{2{prod_q[c][31]}}, prod_q[c]}) +
          34'sd32768;
      if (t[33]) begin
        res_d[c] = 8'd0;
      end else if (|t[32:24]) begin
        res_d[c] = 8'd255;
      end else begin
        res_d[c] = t[23:16];
      end
    end
  end

  assign out_o.valid       = o_v_q;
  assign out_o.out_red     = res_q[0];
  assign out_o.out_green   = res_q[1];
  assign out_o.out_blue    = res_q[2];
  assign out_o.out_alpha   = res_q[3];
  assign out_o.last_in_run = o_last_q;
  assign out_o.frame_end   = o_fend_q;

endmodule

// ----- src/gauss_laplace_sharpen_5x5.sv -----
// path: a pixel's first result is registered in the input stage, kern_q, prod_q and res_q before it leaves
// throughput: one pixel per cycle while the result port is not stalled; the last pixel of each row
// holds the input through its tail steps, since the single result port delivers its up to three
// results one per cycle
// reset: counters, window and config registers take their defaults; line store is not cleared
module gauss_laplace_sharpen_5x5 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i,
  gls_in_if.sink      pix_in,
  gls_out_if.source   pix_out
);

  localparam logic [1:0] STEP_MAIN  = 2'd0;
  localparam logic [1:0] STEP_TAIL1 = 2'd1;
  localparam logic [1:0] STEP_TAIL2 = 2'd2;

  logic [12:0] width_q, height_q;
  logic [17:0] gain_q;
  logic [12:0] eff_w, eff_h;

  logic [gls_pkg::COL_W-1:0] col_q, ocol_q;
  logic [12:0]               row_q;
  logic [11:0]               orow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gls_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[12:0];
        gls_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
        gls_pkg::CFG_SHARPEN_GAIN: gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (width_q == '0) ? 13'd1 :
                 (width_q > 13'(gls_pkg::MAX_WIDTH)) ? 13'(gls_pkg::MAX_WIDTH) : width_q;
  assign eff_h = (height_q == '0) ? 13'd1 :
                 (height_q > 13'(gls_pkg::HEIGHT_LIMIT)) ? 13'(gls_pkg::HEIGHT_LIMIT) : height_q;

  // input side
  logic        in_acc, flush_row, drop, load_s1, lastcol, wr_en;
  gls_pkg::pix_t pix;
  logic [4:0]  usepix_d;
  logic [4:0][gls_pkg::SLOT_W-1:0] slot_d;

  assign in_acc    = pix_in.valid && pix_in.ready;
  assign flush_row = row_q >= eff_h;
  assign drop      = pix_in.command && !flush_row;
  assign load_s1   = in_acc && !drop;
  assign lastcol   = {1'b0, col_q} >= eff_w - 13'd1;
  assign wr_en     = load_s1 && !flush_row;
  assign pix       = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};

  // source row of each window tap, clamped into the frame
  always_comb begin
    logic signed [14:0] r;
    logic [12:0]        rc;
    for (int i = 0; i < 5; i++) begin
      r = $signed({2'b00, row_q}) - 15'sd4 + 15'(i);
      if (r < 0) begin
        rc = '0;
      end else if (r > $signed({2'b00, eff_h}) - 15'sd1) begin
        rc = eff_h - 13'd1;
      end else begin
        rc = r[12:0];
      end
      usepix_d[i] = !flush_row && (rc == row_q);
      slot_d[i]   = rc[gls_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (load_s1) begin
      if (lastcol) begin
        col_q <= '0;
        row_q <= (row_q >= eff_h + 13'd1) ? 13'd0 : row_q + 13'd1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line store: one bank per row slot, read-before-write at the same column
  gls_pkg::pix_t rd_q [gls_pkg::ROW_SLOTS];

  for (genvar b = 0; b < gls_pkg::ROW_SLOTS; b++) begin : g_bank
    gls_pkg::pix_t bank_mem [gls_pkg::MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (load_s1) begin
        rd_q[b] <= bank_mem[col_q];
        if (wr_en && row_q[gls_pkg::SLOT_W-1:0] == gls_pkg::SLOT_W'(b)) begin
          bank_mem[col_q] <= pix;
        end
      end
    end
  end

  // column sequencer
  logic        s1_v_q, fill_q, lastcol_q, y2_q, x2_q, x1_q, wrap_q;
  logic [1:0]  step_q;
  gls_pkg::pix_t s1_pix_q;
  logic [4:0]  usepix_q;
  logic [4:0][gls_pkg::SLOT_W-1:0] slot_q;

  logic        d_v_q, k_ready, s2_free, fire, final_step, emit, fend;
  gls_pkg::col_t col;
  gls_pkg::win_t window_q, window_d;
  gls_pkg::kern_t kern_q, kern_d;

  assign s2_free    = !d_v_q || k_ready;
  assign fire       = s1_v_q && s2_free;
  assign final_step = (step_q == STEP_MAIN && !lastcol_q) || step_q == STEP_TAIL2;
  assign pix_in.ready = !s1_v_q || (fire && final_step);

  always_comb begin
    case (step_q)
      STEP_MAIN:  emit = y2_q && x2_q;
      STEP_TAIL1: emit = y2_q && x1_q;
      STEP_TAIL2: emit = y2_q;
      default:    emit = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      col[i] = usepix_q[i] ? s1_pix_q : rd_q[slot_q[i]];
    end
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (c == 4 || (fill_q && step_q == STEP_MAIN)) begin
          window_d[r][c] = col[r];
        end else begin
          window_d[r][c] = window_q[r][c+1];
        end
      end
    end
  end

  assign fend = ({1'b0, orow_q} >= eff_h - 13'd1) && ({1'b0, ocol_q} >= eff_w - 13'd1);

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      kern_d.dev[ch]    = gls_pkg::kernel_dev(window_d, 2'(ch));
      kern_d.centre[ch] = window_d[2][2][8*ch +: 8];
    end
    kern_d.last = (step_q == STEP_MAIN && !lastcol_q) || step_q == STEP_TAIL2;
    kern_d.fend = fend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      step_q   <= STEP_MAIN;
      d_v_q    <= 1'b0;
      window_q <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      if (load_s1) begin
        s1_v_q <= 1'b1;
        step_q <= STEP_MAIN;
      end else if (fire) begin
        if (final_step) s1_v_q <= 1'b0;
        else step_q <= step_q + 2'd1;
      end
      if (fire) begin
        d_v_q    <= emit;
        window_q <= window_d;
        if (final_step && wrap_q) begin
          ocol_q <= '0;
          orow_q <= '0;
        end else if (emit) begin
          if ({1'b0, ocol_q} + 13'd1 >= eff_w) begin
            ocol_q <= '0;
            orow_q <= orow_q + 12'd1;
          end else begin
            ocol_q <= ocol_q + 1'b1;
          end
        end
      end else if (k_ready) begin
        d_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_pix_q  <= pix;
      usepix_q  <= usepix_d;
      slot_q    <= slot_d;
      fill_q    <= col_q == '0;
      lastcol_q <= lastcol;
      y2_q      <= row_q >= 13'd2;
      x2_q      <= col_q >= gls_pkg::COL_W'(2);
      x1_q      <= col_q != '0;
      wrap_q    <= lastcol && (row_q >= eff_h + 13'd1);
    end
    if (fire && emit) kern_q <= kern_d;
  end

  gls_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gain_i    (gain_q),
    .k_valid_i (d_v_q),
    .k_ready_o (k_ready),
    .k_i       (kern_q),
    .out_o     (pix_out)
  );

endmodule

// ----- src/gls_checker.sv -----
module gls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha,
  input logic       last_in_run,
  input logic       frame_end
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_alpha) &&
    $stable(frame_end) && $stable(last_in_run))
    else $error("stalled result changed");

  // the frame's last pixel closes the run of its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_end |-> last_in_run)
    else $error("frame end without run end");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result during reset");

endmodule

bind gauss_laplace_sharpen_5x5 gls_checker u_gls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_red     (pix_out.out_red),
  .out_alpha   (pix_out.out_alpha),
  .last_in_run (pix_out.last_in_run),
  .frame_end   (pix_out.frame_end)
);
